// File: design/laser_scan_light_cluster_detector_assert.svh
// assertion macros for the light cluster detector
`ifndef LASER_SCAN_LIGHT_CLUSTER_DETECTOR_ASSERT_SVH
`define LASER_SCAN_LIGHT_CLUSTER_DETECTOR_ASSERT_SVH

// same-cycle implication, inactive while reset is asserted
`define LSCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, inactive while reset is asserted
`define LSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/lscd_pkg.sv
// shared types, constants and the cosine table of the light cluster detector
`timescale 1ns / 1ps
package lscd_pkg;

	localparam int DIST_BITS     = 16;
	localparam int CFG_BITS      = 16;
	localparam int ANG_BITS      = 9;
	localparam int COS_FRAC_BITS = 15;
	localparam int ANGLE_STEPS   = 360;
	localparam int QUARTER       = ANGLE_STEPS / 4;
	localparam int COS_W         = COS_FRAC_BITS + 1;
	localparam int COS_IDX_W     = $clog2(QUARTER + 1);

	// serial multiplier operand width for the first pass
	localparam int MUL_W     = DIST_BITS + 1;
	localparam int MUL_P_W   = 2 * MUL_W;
	localparam int SQ_W      = 2 * DIST_BITS + 1;
	localparam int TWOAB_W   = 2 * DIST_BITS + 1;
	localparam int TC_W      = TWOAB_W + COS_W;
	localparam int TERM_W    = TC_W - COS_FRAC_BITS;
	localparam int C2_W      = ((TERM_W > SQ_W) ? TERM_W : SQ_W) + 1;

	localparam int PTS_W = 3;
	localparam logic [PTS_W-1:0] PTS_FULL = 3'd5;

	localparam logic [CFG_BITS-1:0] RST_MIN_RANGE = 16'd0;
	localparam logic [CFG_BITS-1:0] RST_MAX_RANGE = 16'hFFFF;
	localparam logic [CFG_BITS-1:0] RST_JUMP      = 16'd100;
	localparam logic [CFG_BITS-1:0] RST_DIAMETER  = 16'd80;
	localparam logic [CFG_BITS-1:0] RST_TOLERANCE = 16'd20;

	localparam logic [63:0] Q30_COS1 = 64'd1073578288;
	localparam logic [63:0] Q30_SIN1 = 64'd18739379;

	typedef enum logic [2:0] {
		REG_MIN_RANGE = 3'd0,
		REG_MAX_RANGE = 3'd1,
		REG_JUMP      = 3'd2,
		REG_DIAMETER  = 3'd3,
		REG_TOLERANCE = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_EVAL,
		CTL_CHORD,
		CTL_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		CH_IDLE,
		CH_PROD,
		CH_TERM,
		CH_CMP
	} chord_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIST_BITS-1:0] dist_a;
		logic [DIST_BITS-1:0] dist_b;
		logic [ANG_BITS-1:0]  ang_a;
		logic [ANG_BITS-1:0]  ang_b;
	} chord_req_t;

	typedef struct packed {
		logic done;
		logic match;
	} chord_rsp_t;

	typedef struct packed {
		logic             neg;
		logic [COS_W-1:0] mag;
	} cos_t;

	typedef logic [COS_W-1:0] cos_rom_t [0:QUARTER];

	// quarter-wave cosine by integer rotation in q30, then rounded to COS_FRAC_BITS
	function automatic cos_rom_t build_cos_rom();
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] nc;
		logic [63:0] ns;
		logic [63:0] r;
		cos_rom_t rom;
		int k;
		c = 64'd1 << 30;
		s = 64'd0;
		rom[0] = COS_W'((c + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS));
		for (k = 1; k <= QUARTER; k++) begin
			p = c * Q30_COS1;
			q = s * Q30_SIN1;
			nc = (p > q) ? p - q : 64'd0;
			ns = s * Q30_COS1 + c * Q30_SIN1;
			c = (nc + (64'd1 << 29)) >> 30;
			s = (ns + (64'd1 << 29)) >> 30;
			r = (c + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
			rom[k] = COS_W'(r);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

	// magnitude and sign of the cosine of d, d already reduced below 360
	function automatic cos_t cos_lookup(input logic [ANG_BITS-1:0] d);
		cos_t res;
		logic [ANG_BITS-1:0] idx;
		res.neg = 1'b0;
		if (d <= ANG_BITS'(QUARTER)) begin
			idx = d;
		end else if (d <= ANG_BITS'(2 * QUARTER)) begin
			idx = ANG_BITS'(2 * QUARTER) - d;
			res.neg = 1'b1;
		end else if (d < ANG_BITS'(3 * QUARTER)) begin
			idx = d - ANG_BITS'(2 * QUARTER);
			res.neg = 1'b1;
		end else begin
			idx = ANG_BITS'(ANGLE_STEPS) - d;
		end
		res.mag = COS_ROM[idx[COS_IDX_W-1:0]];
		return res;
	endfunction

endpackage

// File: design/lscd_sermul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module lscd_sermul #(
	parameter int XW = lscd_pkg::MUL_W,
	parameter int YW = lscd_pkg::MUL_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [XW-1:0]   x,
	input  logic [YW-1:0]   y,
	output logic            done,
	output logic [XW+YW-1:0] product
);
	import lscd_pkg::*;

	localparam int PW = XW + YW;
	localparam int CW = $clog2(YW + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] xs_q;
	logic [YW-1:0] ys_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q  <= CW'(YW);
				done_q <= 1'b0;
			end else begin
				done_q <= (cnt_q == CW'(1));
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= '0;
			xs_q  <= PW'(x);
			ys_q  <= y;
		end else if (cnt_q != '0) begin
			if (ys_q[0]) begin
				acc_q <= acc_q + xs_q;
			end
			xs_q <= xs_q << 1;
			ys_q <= ys_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// File: design/lscd_chord.sv
// chord test between two peaks: law of cosines with bit-serial products
`timescale 1ns / 1ps
module lscd_chord (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lscd_pkg::chord_req_t           req,
	input  logic [lscd_pkg::CFG_BITS-1:0]  diameter,
	input  logic [lscd_pkg::CFG_BITS-1:0]  tolerance,
	output lscd_pkg::chord_rsp_t           rsp
);
	import lscd_pkg::*;

	chord_state_t state_q, state_d;

	logic [ANG_BITS-1:0] d_q;
	logic [ANG_BITS-1:0] d_raw;
	logic [ANG_BITS-1:0] d_mod;
	cos_t                cos_v;

	logic [MUL_W-1:0]   a_ext, b_ext, hi_ext, lo_ext;
	logic [MUL_P_W-1:0] aa_p, bb_p, ab_p, hi_p, lo_p;
	logic               pass1_done, term_done, pass1_load, term_load;
	logic [TWOAB_W-1:0] two_ab;
	logic [TC_W-1:0]    tc_p;
	logic [TERM_W-1:0]  term;
	logic [SQ_W-1:0]    sq_q;
	logic [C2_W-1:0]    c2_q;
	logic [C2_W-1:0]    sq_ext, term_ext, c2_d;
	logic               lo_en;
	logic               match;

	// absolute angle difference modulo a full turn
	always_comb begin
		d_raw = (req.ang_a >= req.ang_b) ? req.ang_a - req.ang_b : req.ang_b - req.ang_a;
		d_mod = (d_raw >= ANG_BITS'(ANGLE_STEPS)) ? d_raw - ANG_BITS'(ANGLE_STEPS) : d_raw;
	end

	assign cos_v = cos_lookup(d_q);

	assign a_ext  = MUL_W'(req.dist_a);
	assign b_ext  = MUL_W'(req.dist_b);
	assign hi_ext = MUL_W'(diameter) + MUL_W'(tolerance);
	assign lo_ext = MUL_W'(diameter - tolerance);
	assign lo_en  = diameter > tolerance;

	assign pass1_load = (state_q == CH_IDLE) && req.start;
	assign term_load  = (state_q == CH_PROD) && pass1_done;

	lscd_sermul #(.XW(MUL_W), .YW(MUL_W)) u_mul_aa (
		.clk(clk), .arst_n(arst_n), .load(pass1_load),
		.x(a_ext), .y(a_ext), .done(pass1_done), .product(aa_p)
	);
	lscd_sermul #(.XW(MUL_W), .YW(MUL_W)) u_mul_bb (
		.clk(clk), .arst_n(arst_n), .load(pass1_load),
		.x(b_ext), .y(b_ext), .done(), .product(bb_p)
	);
	lscd_sermul #(.XW(MUL_W), .YW(MUL_W)) u_mul_ab (
		.clk(clk), .arst_n(arst_n), .load(pass1_load),
		.x(a_ext), .y(b_ext), .done(), .product(ab_p)
	);
	lscd_sermul #(.XW(MUL_W), .YW(MUL_W)) u_mul_hi (
		.clk(clk), .arst_n(arst_n), .load(pass1_load),
		.x(hi_ext), .y(hi_ext), .done(), .product(hi_p)
	);
	lscd_sermul #(.XW(MUL_W), .YW(MUL_W)) u_mul_lo (
		.clk(clk), .arst_n(arst_n), .load(pass1_load),
		.x(lo_ext), .y(lo_ext), .done(), .product(lo_p)
	);

	assign two_ab = {ab_p[2*DIST_BITS-1:0], 1'b0};

	// second pass: 2ab times the cosine magnitude
	lscd_sermul #(.XW(TWOAB_W), .YW(COS_W)) u_mul_term (
		.clk(clk), .arst_n(arst_n), .load(term_load),
		.x(two_ab), .y(cos_v.mag), .done(term_done), .product(tc_p)
	);

	assign term     = tc_p[TC_W-1:COS_FRAC_BITS];
	assign sq_ext   = C2_W'(sq_q);
	assign term_ext = C2_W'(term);

	always_comb begin
		if (cos_v.neg) begin
			c2_d = sq_ext + term_ext;
		end else if (sq_ext > term_ext) begin
			c2_d = sq_ext - term_ext;
		end else begin
			c2_d = '0;
		end
	end

	assign match = !(c2_q > C2_W'(hi_p)) && !(lo_en && (c2_q < C2_W'(lo_p)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pass1_load) begin
			d_q <= d_mod;
		end
		if (term_load) begin
			sq_q <= SQ_W'(aa_p) + SQ_W'(bb_p);
		end
		if ((state_q == CH_TERM) && term_done) begin
			c2_q <= c2_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CH_IDLE: if (req.start) state_d = CH_PROD;
			CH_PROD: if (pass1_done) state_d = CH_TERM;
			CH_TERM: if (term_done) state_d = CH_CMP;
			CH_CMP:  state_d = CH_IDLE;
			default: state_d = CH_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = (state_q == CH_CMP);
		rsp.match = (state_q == CH_CMP) && match;
	end

endmodule

// File: design/laser_scan_light_cluster_detector.sv
// top level: reading window, peak detection, result register and configuration
// an item that ends its scan without a chord test passes the eval and emit states into the result register
// items are taken one at a time: the next waits until control is back in idle
// the chord test runs two bit-serial multiply passes of 17 and 16 steps
// async active-low reset clears control state and loads register defaults
// no clearing pass: the window refills from the first reading of every scan
`timescale 1ns / 1ps
`include "laser_scan_light_cluster_detector_assert.svh"
module laser_scan_light_cluster_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [2:0]                      cfg_index,
	input  logic [lscd_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [lscd_pkg::DIST_BITS-1:0]  distance_mm,
	input  logic                            reading_finite,
	input  logic [lscd_pkg::ANG_BITS-1:0]   angle_deg,
	input  logic                            first_in_scan,
	input  logic                            last_in_scan,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            light_found,
	output logic [lscd_pkg::ANG_BITS-1:0]   light_angle_deg,
	output logic [lscd_pkg::DIST_BITS-1:0]  light_distance_mm,
	output logic                            scan_done,
	output logic                            too_few_points
);
	import lscd_pkg::*;

	// configuration registers
	logic [CFG_BITS-1:0] min_range_q, max_range_q, jump_q, diameter_q, tolerance_q;

	ctl_state_t state_q, state_d;

	// captured item
	logic [DIST_BITS-1:0] dist_s1;
	logic [ANG_BITS-1:0]  ang_s1;
	logic                 ok_s1, first_s1, last_s1;

	// five-reading window: four stored readings plus the one in hand
	logic [DIST_BITS-1:0] win_dist_q [4];
	logic [ANG_BITS-1:0]  win_ang_q  [4];
	logic [3:0]           win_ok_q;

	// previous peak
	logic [DIST_BITS-1:0] peak_dist_q;
	logic [ANG_BITS-1:0]  peak_ang_q;
	logic                 peak_ok_q;

	logic [PTS_W-1:0] pts_q;

	// pending result
	logic                 found_q, last_q, few_q;
	logic [ANG_BITS-1:0]  f_ang_q;
	logic [DIST_BITS-1:0] f_dist_q;

	// result register
	logic                 res_valid_q, res_found_q, res_done_q, res_few_q;
	logic [ANG_BITS-1:0]  res_ang_q;
	logic [DIST_BITS-1:0] res_dist_q;

	logic                 accept, in_ok;
	logic                 scan_start, jump, is_peak, do_test, emit_fire;
	logic [PTS_W-1:0]     pts_inc;
	logic [DIST_BITS-1:0] jump_diff;
	logic [ANG_BITS:0]    ang_sum;
	logic [DIST_BITS:0]   dist_sum;

	chord_req_t chord_req;
	chord_rsp_t chord_rsp;

	assign accept = item_valid && !item_stall;
	assign in_ok  = reading_finite && (distance_mm > min_range_q) && (distance_mm < max_range_q);

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= RST_MIN_RANGE;
			max_range_q <= RST_MAX_RANGE;
			jump_q      <= RST_JUMP;
			diameter_q  <= RST_DIAMETER;
			tolerance_q <= RST_TOLERANCE;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_MIN_RANGE: min_range_q <= cfg_data;
				REG_MAX_RANGE: max_range_q <= cfg_data;
				REG_JUMP:      jump_q      <= cfg_data;
				REG_DIAMETER:  diameter_q  <= cfg_data;
				REG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// peak decision on the middle reading (window slot 2)
	always_comb begin
		scan_start = first_s1 || (pts_q == '0);
		if (scan_start) begin
			pts_inc = PTS_W'(1);
		end else if (pts_q < PTS_FULL) begin
			pts_inc = pts_q + PTS_W'(1);
		end else begin
			pts_inc = PTS_FULL;
		end
		jump_diff = (win_dist_q[1] > win_dist_q[2]) ? win_dist_q[1] - win_dist_q[2]
		                                            : win_dist_q[2] - win_dist_q[1];
		// an invalid predecessor counts as a jump
		jump = !win_ok_q[1] || (jump_diff > jump_q);
		is_peak = !scan_start && (pts_inc == PTS_FULL) && win_ok_q[2]
		          && (jump || (!win_ok_q[1] && !win_ok_q[0]) || (!win_ok_q[3] && !ok_s1));
		do_test = is_peak && peak_ok_q;
		// midpoint and mean use the previous peak before it is replaced
		ang_sum  = {1'b0, win_ang_q[2]} + {1'b0, peak_ang_q};
		dist_sum = {1'b0, win_dist_q[2]} + {1'b0, peak_dist_q};
	end

	always_comb begin
		chord_req.start  = (state_q == CTL_EVAL) && do_test;
		chord_req.dist_a = peak_dist_q;
		chord_req.dist_b = win_dist_q[2];
		chord_req.ang_a  = win_ang_q[2];
		chord_req.ang_b  = peak_ang_q;
	end

	lscd_chord u_chord (
		.clk(clk),
		.arst_n(arst_n),
		.req(chord_req),
		.diameter(diameter_q),
		.tolerance(tolerance_q),
		.rsp(chord_rsp)
	);

	// result register frees as soon as the held item is taken
	assign emit_fire = (state_q == CTL_EMIT) && (!res_valid_q || !result_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (accept) state_d = CTL_EVAL;
			end
			CTL_EVAL: begin
				if (do_test) state_d = CTL_CHORD;
				else if (last_s1) state_d = CTL_EMIT;
				else state_d = CTL_IDLE;
			end
			CTL_CHORD: begin
				if (chord_rsp.done) begin
					state_d = (chord_rsp.match || last_q) ? CTL_EMIT : CTL_IDLE;
				end
			end
			CTL_EMIT: begin
				if (emit_fire) state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	always_comb begin
		item_stall = (state_q != CTL_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			pts_q       <= '0;
			win_ok_q    <= '0;
			peak_ok_q   <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == CTL_EVAL) begin
				pts_q    <= last_s1 ? '0 : pts_inc;
				win_ok_q <= {ok_s1, win_ok_q[3:1]};
				found_q  <= 1'b0;
				if (scan_start) begin
					peak_ok_q <= ok_s1;
				end else if (is_peak) begin
					peak_ok_q <= 1'b1;
				end
			end
			if ((state_q == CTL_CHORD) && chord_rsp.done) begin
				found_q <= chord_rsp.match;
			end
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dist_s1  <= distance_mm;
			ang_s1   <= angle_deg;
			ok_s1    <= in_ok;
			first_s1 <= first_in_scan;
			last_s1  <= last_in_scan;
		end
		if (state_q == CTL_EVAL) begin
			// window shift line, newest reading into slot 3
			win_dist_q[0] <= win_dist_q[1];
			win_dist_q[1] <= win_dist_q[2];
			win_dist_q[2] <= win_dist_q[3];
			win_dist_q[3] <= ok_s1 ? dist_s1 : '0;
			win_ang_q[0]  <= win_ang_q[1];
			win_ang_q[1]  <= win_ang_q[2];
			win_ang_q[2]  <= win_ang_q[3];
			win_ang_q[3]  <= ang_s1;
			if (scan_start) begin
				peak_dist_q <= ok_s1 ? dist_s1 : '0;
				peak_ang_q  <= ang_s1;
			end else if (is_peak) begin
				peak_dist_q <= win_dist_q[2];
				peak_ang_q  <= win_ang_q[2];
			end
			f_ang_q  <= ang_sum[ANG_BITS:1];
			f_dist_q <= dist_sum[DIST_BITS:1];
			last_q   <= last_s1;
			few_q    <= last_s1 && (pts_inc != PTS_FULL);
		end
		if (emit_fire) begin
			res_found_q <= found_q;
			res_ang_q   <= found_q ? f_ang_q : '0;
			res_dist_q  <= found_q ? f_dist_q : '0;
			res_done_q  <= last_q;
			res_few_q   <= few_q;
		end
	end

	assign result_valid      = res_valid_q;
	assign light_found       = res_found_q;
	assign light_angle_deg   = res_ang_q;
	assign light_distance_mm = res_dist_q;
	assign scan_done         = res_done_q;
	assign too_few_points    = res_few_q;

	// a result without a light is only ever the scan end marker
	`LSCD_ASSERT_IMPL(a_empty_result_ends_scan, clk, arst_n, result_valid && !light_found, scan_done)
	// a short scan never reaches a chord test, so it reports no light
	`LSCD_ASSERT_IMPL(a_short_scan_no_light, clk, arst_n, result_valid && too_few_points, !light_found && scan_done)
	// the reading counter saturates at the full window
	`LSCD_ASSERT_IMPL(a_points_saturate, clk, arst_n, 1'b1, pts_q <= PTS_FULL)
	// one item at a time: the block is busy right after taking an item
	`LSCD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)

endmodule

// File: tb/sv/tb_laser_scan_light_cluster_detector.sv
// testbench for the light cluster detector: directed and random scans against a local predictor
`timescale 1ns / 1ps
module tb_laser_scan_light_cluster_detector;
	import lscd_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 9;
	// a reading with no report may still be in its chord test
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MISMATCH_SHOWN = 10;
	localparam int FULL_TURN      = 360;
	localparam int QUARTER_TURN   = 90;
	localparam int COS_FRAC       = COS_FRAC_BITS;
	// one-degree rotation step of the cosine table, q30
	localparam logic [63:0] ROT_COS = 64'd1073578288;
	localparam logic [63:0] ROT_SIN = 64'd18739379;
	// chord of 80 mm over one degree is seen at about this range
	localparam int RANGE_PER_DEG  = 4584;

	// one reading as offered to the block
	typedef struct packed {
		logic [DIST_BITS-1:0] range_mm;
		logic                 fin;
		logic [ANG_BITS-1:0]  ang;
		logic                 first;
		logic                 last;
	} reading_t;

	// one light report as it leaves the block
	typedef struct packed {
		logic                 found;
		logic [ANG_BITS-1:0]  ang;
		logic [DIST_BITS-1:0] mean_mm;
		logic                 done;
		logic                 short_scan;
	} light_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [2:0]           cfg_index;
	logic [CFG_BITS-1:0]  cfg_data;
	logic                 item_valid;
	logic                 item_stall;
	logic [DIST_BITS-1:0] distance_mm;
	logic                 reading_finite;
	logic [ANG_BITS-1:0]  angle_deg;
	logic                 first_in_scan;
	logic                 last_in_scan;
	logic                 result_valid;
	logic                 result_stall;
	logic                 light_found;
	logic [ANG_BITS-1:0]  light_angle_deg;
	logic [DIST_BITS-1:0] light_distance_mm;
	logic                 scan_done;
	logic                 too_few_points;

	laser_scan_light_cluster_detector dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.distance_mm      (distance_mm),
		.reading_finite   (reading_finite),
		.angle_deg        (angle_deg),
		.first_in_scan    (first_in_scan),
		.last_in_scan     (last_in_scan),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.light_found      (light_found),
		.light_angle_deg  (light_angle_deg),
		.light_distance_mm(light_distance_mm),
		.scan_done        (scan_done),
		.too_few_points   (too_few_points)
	);

	// predictor copy of the registers
	logic [CFG_BITS-1:0] lim_min, lim_max, lim_jump, light_diam, light_tol;

	// predictor copy of the reading window and the last edge peak
	logic                 win_ok   [4];
	logic [DIST_BITS-1:0] win_dist [4];
	logic [ANG_BITS-1:0]  win_ang  [4];
	logic [DIST_BITS-1:0] edge_dist;
	logic [ANG_BITS-1:0]  edge_ang;
	logic                 edge_ok;
	int                   readings_in_scan;

	logic [63:0]   cos_q15 [0:QUARTER_TURN];
	light_report_t pending_reports [$];

	// random scan under construction
	reading_t            scan_buf [$];
	logic [ANG_BITS-1:0] scan_angle;
	int                  scan_step;

	// idling knobs, percent of cycles, and a requested hold-off length
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;

	int readings_sent;
	int reports_checked;
	int lights_checked;
	int short_scans;
	int reg_programs;
	int hold_offs;
	int mismatches;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// quarter-wave cosine, q30 rotation then rounded half up to q15
	function automatic void build_cosine_table();
		logic [63:0] c, s, p, q, nc, ns;
		c = 64'd1 << 30;
		s = 64'd0;
		cos_q15[0] = c;
		for (int k = 1; k <= QUARTER_TURN; k++) begin
			p = c * ROT_COS;
			q = s * ROT_SIN;
			nc = (p > q) ? p - q : 64'd0;
			ns = s * ROT_COS + c * ROT_SIN;
			c = (nc + (64'd1 << 29)) >> 30;
			s = (ns + (64'd1 << 29)) >> 30;
			cos_q15[k] = c;
		end
		for (int k = 0; k <= QUARTER_TURN; k++)
			cos_q15[k] = (cos_q15[k] + (64'd1 << (29 - COS_FRAC))) >> (30 - COS_FRAC);
	endfunction

	function automatic void reset_predictor();
		lim_min    = RST_MIN_RANGE;
		lim_max    = RST_MAX_RANGE;
		lim_jump   = RST_JUMP;
		light_diam = RST_DIAMETER;
		light_tol  = RST_TOLERANCE;
		for (int i = 0; i < 4; i++) begin
			win_ok[i]   = 1'b0;
			win_dist[i] = '0;
			win_ang[i]  = '0;
		end
		edge_dist = '0;
		edge_ang = '0;
		edge_ok = 1'b0;
		readings_in_scan = 0;
	endfunction

	// law of cosines, squared chord against the diameter window
	function automatic logic chord_fits_light(input logic [DIST_BITS-1:0] a, b,
			input logic [ANG_BITS-1:0] ang_a, ang_b);
		logic [63:0] d, two_ab, sq, mag, term, c2, hi, lo, fmask;
		logic neg;
		d = (ang_a >= ang_b) ? 64'(ang_a) - 64'(ang_b) : 64'(ang_b) - 64'(ang_a);
		d = d % FULL_TURN;
		neg = 1'b0;
		if (d <= QUARTER_TURN) begin
			mag = cos_q15[d];
		end else if (d <= 2 * QUARTER_TURN) begin
			mag = cos_q15[2 * QUARTER_TURN - d];
			neg = 1'b1;
		end else if (d < 3 * QUARTER_TURN) begin
			mag = cos_q15[d - 2 * QUARTER_TURN];
			neg = 1'b1;
		end else begin
			mag = cos_q15[(FULL_TURN - d) % (QUARTER_TURN + 1)];
		end
		fmask = (64'd1 << COS_FRAC) - 64'd1;
		two_ab = 64'(a) * 64'(b) * 64'd2;
		sq = 64'(a) * 64'(a) + 64'(b) * 64'(b);
		term = (two_ab >> COS_FRAC) * mag + (((two_ab & fmask) * mag) >> COS_FRAC);
		if (neg)
			c2 = sq + term;
		else
			c2 = (sq > term) ? sq - term : 64'd0;
		hi = 64'(light_diam) + 64'(light_tol);
		if (c2 > hi * hi)
			return 1'b0;
		// tolerance not below the diameter drops the lower bound
		if (light_diam > light_tol) begin
			lo = 64'(light_diam - light_tol);
			if (c2 < lo * lo)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the window by one accepted reading, queue the report it causes
	function automatic void predict_reading(input reading_t r);
		logic ok, found, jump;
		logic [DIST_BITS-1:0] gap, cd;
		logic [ANG_BITS-1:0] ca;
		light_report_t rep;
		ok = r.fin && r.range_mm > lim_min && r.range_mm < lim_max;
		found = 1'b0;
		rep = '0;
		// scan start: explicit flag, or the first reading after reset or scan end
		if (r.first || readings_in_scan == 0) begin
			for (int i = 0; i < 4; i++) begin
				win_ok[i]   = 1'b0;
				win_dist[i] = '0;
				win_ang[i]  = '0;
			end
			readings_in_scan = 0;
			edge_ok = ok;
			edge_dist = ok ? r.range_mm : '0;
			edge_ang = r.ang;
		end
		if (readings_in_scan < 5)
			readings_in_scan++;
		if (readings_in_scan >= 5) begin
			cd = win_dist[2];
			ca = win_ang[2];
			gap = (win_dist[1] > cd) ? win_dist[1] - cd : cd - win_dist[1];
			// an invalid predecessor counts as a jump
			jump = !win_ok[1] || gap > lim_jump;
			if (win_ok[2] && (jump || (!win_ok[1] && !win_ok[0]) || (!win_ok[3] && !ok))) begin
				if (edge_ok && chord_fits_light(edge_dist, cd, ca, edge_ang)) begin
					found = 1'b1;
					rep.ang = ANG_BITS'(((ANG_BITS + 1)'(ca) + (ANG_BITS + 1)'(edge_ang)) >> 1);
					rep.mean_mm = DIST_BITS'(((DIST_BITS + 1)'(edge_dist)
						+ (DIST_BITS + 1)'(cd)) >> 1);
				end
				edge_dist = cd;
				edge_ang = ca;
				edge_ok = 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			win_ok[i]   = win_ok[i + 1];
			win_dist[i] = win_dist[i + 1];
			win_ang[i]  = win_ang[i + 1];
		end
		win_ok[3]   = ok;
		win_dist[3] = ok ? r.range_mm : '0;
		win_ang[3]  = r.ang;
		if (found || r.last) begin
			rep.found = found;
			rep.done = r.last;
			rep.short_scan = r.last && readings_in_scan < 5;
			pending_reports = {pending_reports, rep};
		end
		if (r.last)
			readings_in_scan = 0;
	endfunction

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------

	// offer one reading, idling first at random; returns at the accepting edge
	task automatic offer_reading(input logic [DIST_BITS-1:0] range_mm, input logic fin,
			input logic [ANG_BITS-1:0] ang, input logic first, input logic last);
		reading_t r;
		r = '{range_mm: range_mm, fin: fin, ang: ang, first: first, last: last};
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid     <= 1'b1;
		distance_mm    <= r.range_mm;
		reading_finite <= r.fin;
		angle_deg      <= r.ang;
		first_in_scan  <= r.first;
		last_in_scan   <= r.last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_reading(r);
		readings_sent++;
	endtask

	// drop valid and wait until every queued report has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
	endtask

	// block fully idle: reports back, and time for a chord test that gives none
	task automatic settle_block();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all five registers on consecutive edges, only while idle
	task automatic program_registers(input logic [CFG_BITS-1:0] min_v, max_v, jump_v,
			diam_v, tol_v);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_MIN_RANGE;
		cfg_data <= min_v;
		@(posedge clk);
		cfg_index <= REG_MAX_RANGE;
		cfg_data <= max_v;
		@(posedge clk);
		cfg_index <= REG_JUMP;
		cfg_data <= jump_v;
		@(posedge clk);
		cfg_index <= REG_DIAMETER;
		cfg_data <= diam_v;
		@(posedge clk);
		cfg_index <= REG_TOLERANCE;
		cfg_data <= tol_v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		lim_min = min_v;
		lim_max = max_v;
		lim_jump = jump_v;
		light_diam = diam_v;
		light_tol = tol_v;
		reg_programs++;
	endtask

	// ------------------------------------------------------------------
	// random scan shapes
	// ------------------------------------------------------------------

	function automatic void push_reading(input int range_mm, input logic fin);
		reading_t r;
		r = '0;
		r.range_mm = DIST_BITS'(range_mm);
		r.fin = fin;
		r.ang = scan_angle;
		scan_buf = {scan_buf, r};
		scan_angle = ANG_BITS'(scan_angle + scan_step);
	endfunction

	// not finite, at the lower limit, or at the upper limit
	function automatic void push_invalid_run(input int n);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: push_reading(int'($urandom_range(0, 65535)), 1'b0);
				1: push_reading(0, 1'b1);
				default: push_reading(65535, 1'b1);
			endcase
		end
	endfunction

	// mostly well-formed scans: invalid gaps, walls and light-sized clusters
	task automatic send_random_scan();
		int target, k, base, pick;
		reading_t noise;
		scan_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			// noise: every field at random
			repeat ($urandom_range(1, 8)) begin
				noise.range_mm = DIST_BITS'($urandom_range(0, 65535));
				noise.fin = 1'($urandom_range(0, 1));
				noise.ang = ANG_BITS'($urandom_range(0, 511));
				noise.first = 1'($urandom_range(0, 1));
				noise.last = 1'($urandom_range(0, 1));
				scan_buf = {scan_buf, noise};
			end
		end else begin
			target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(6, 40);
			scan_angle = ANG_BITS'($urandom_range(0, 330));
			scan_step = ($urandom_range(0, 7) == 0) ? 2 : 1;
			while (scan_buf.size() < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					push_invalid_run($urandom_range(2, 3));
				end else if (pick < 55) begin
					base = $urandom_range(300, 6000);
					repeat ($urandom_range(2, 6))
						push_reading(base + int'($urandom_range(0, 60)) - 30, 1'b1);
				end else begin
					// cluster whose edge chord lands near the diameter window
					if ($urandom_range(0, 4) != 0)
						push_invalid_run(2);
					k = $urandom_range(1, 4);
					base = (RANGE_PER_DEG / k) * int'($urandom_range(75, 125)) / 100;
					repeat (k + 1)
						push_reading(base + int'($urandom_range(0, 6)) - 3, 1'b1);
					if ($urandom_range(0, 4) != 0)
						push_invalid_run(2);
				end
			end
			while (scan_buf.size() > target)
				void'(scan_buf.pop_back());
			// broken sequences now and then: missing flags, restart mid scan
			scan_buf[0].first = ($urandom_range(0, 9) != 0);
			scan_buf[scan_buf.size() - 1].last = ($urandom_range(0, 9) != 0);
			if (scan_buf.size() > 6 && $urandom_range(0, 19) == 0)
				scan_buf[$urandom_range(3, scan_buf.size() - 1)].first = 1'b1;
		end
		foreach (scan_buf[i])
			offer_reading(scan_buf[i].range_mm, scan_buf[i].fin, scan_buf[i].ang,
				scan_buf[i].first, scan_buf[i].last);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// runs under the register values after reset
	task automatic test_directed_cases();
		// first reading after reset opens a scan without the flag; field extremes
		offer_reading(16'd0, 1'b1, 9'd0, 1'b0, 1'b0);
		offer_reading(16'hFFFF, 1'b1, 9'd359, 1'b0, 1'b0);
		// short scan
		offer_reading(16'd1, 1'b0, 9'h1FF, 1'b0, 1'b1);
		// light between invalid runs, scan opened by the reading after a scan end
		offer_reading(16'd0, 1'b0, 9'd100, 1'b0, 1'b0);
		offer_reading(16'd0, 1'b0, 9'd101, 1'b0, 1'b0);
		offer_reading(16'd2290, 1'b1, 9'd102, 1'b0, 1'b0);
		offer_reading(16'd2290, 1'b1, 9'd103, 1'b0, 1'b0);
		offer_reading(16'd2290, 1'b1, 9'd104, 1'b0, 1'b0);
		offer_reading(16'd0, 1'b0, 9'd105, 1'b0, 1'b0);
		offer_reading(16'd0, 1'b0, 9'd106, 1'b0, 1'b0);
		// wall after the light, range limits on both sides
		offer_reading(16'd3000, 1'b1, 9'd107, 1'b0, 1'b0);
		offer_reading(16'd3010, 1'b1, 9'd108, 1'b0, 1'b0);
		offer_reading(16'hFFFF, 1'b1, 9'd109, 1'b0, 1'b0);
		offer_reading(16'd0, 1'b1, 9'd110, 1'b0, 1'b0);
		offer_reading(16'd3020, 1'b1, 9'd111, 1'b0, 1'b1);
		// restart mid scan, then angles past a full turn
		offer_reading(16'd1500, 1'b1, 9'd300, 1'b1, 1'b0);
		offer_reading(16'd1380, 1'b1, 9'd301, 1'b0, 1'b0);
		offer_reading(16'd0, 1'b0, 9'd302, 1'b0, 1'b0);
		offer_reading(16'd5000, 1'b1, 9'd350, 1'b1, 1'b0);
		offer_reading(16'd5000, 1'b1, 9'd351, 1'b0, 1'b0);
		offer_reading(16'd40, 1'b1, 9'd400, 1'b0, 1'b0);
		offer_reading(16'd40, 1'b1, 9'd401, 1'b0, 1'b0);
		offer_reading(16'd4580, 1'b1, 9'd510, 1'b0, 1'b0);
		offer_reading(16'd4580, 1'b1, 9'd511, 1'b0, 1'b0);
		offer_reading(16'd65534, 1'b1, 9'd2, 1'b0, 1'b1);
	endtask

	// each register at both ends of its range
	task automatic test_register_extremes();
		settle_block();
		program_registers(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		send_random_scan();
		send_random_scan();
		settle_block();
		program_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_random_scan();
		send_random_scan();
		settle_block();
		// nothing can be valid
		program_registers(16'hFFFF, 16'hFFFF, 16'd100, 16'd80, 16'd20);
		send_random_scan();
		settle_block();
		program_registers(16'd0, 16'd0, 16'd100, 16'd80, 16'd20);
		send_random_scan();
		settle_block();
		// tolerance equal to the diameter
		program_registers(16'd1000, 16'd5000, 16'd100, 16'd80, 16'd80);
		send_random_scan();
		send_random_scan();
		settle_block();
		program_registers(16'd10, 16'd60000, 16'd150, 16'd100, 16'd30);
		send_random_scan();
		send_random_scan();
	endtask

	// random register values between chunks, sender pauses until drained each time
	task automatic test_random_scans(input int count);
		int goal;
		goal = readings_sent + count;
		while (readings_sent < goal) begin
			settle_block();
			program_registers(CFG_BITS'($urandom_range(0, 200)),
				CFG_BITS'($urandom_range(6000, 65535)),
				CFG_BITS'($urandom_range(30, 400)),
				$urandom_range(0, 1) ? CFG_BITS'(80) : CFG_BITS'($urandom_range(30, 200)),
				CFG_BITS'($urandom_range(0, 60)));
			repeat (4)
				send_random_scan();
		end
	endtask

	// long output hold-off while one-reading scans keep coming, then drain
	task automatic test_output_hold_off();
		hold_request = HOLD_CYCLES;
		repeat (30)
			offer_reading(DIST_BITS'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				ANG_BITS'($urandom_range(0, 511)), 1'b1, 1'b1);
		send_random_scan();
		hold_offs++;
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// receiver: random stall, long hold-off when asked
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// report checker: every accepted report against the oldest expectation
	// ------------------------------------------------------------------
	function automatic string describe(input light_report_t r);
		return $sformatf("found=%0d angle=%0d distance=%0d done=%0d short=%0d",
			r.found, r.ang, r.mean_mm, r.done, r.short_scan);
	endfunction

	initial begin
		light_report_t got, want;
		string bad;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				got.found = light_found;
				got.ang = light_angle_deg;
				got.mean_mm = light_distance_mm;
				got.done = scan_done;
				got.short_scan = too_few_points;
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOWN)
						$display("unexpected report: %s", describe(got));
				end else begin
					want = pending_reports.pop_front();
					reports_checked++;
					if (want.found)
						lights_checked++;
					if (want.short_scan)
						short_scans++;
					bad = "";
					if (got.found !== want.found)
						bad = {bad, " light_found"};
					if (got.ang !== want.ang)
						bad = {bad, " light_angle_deg"};
					if (got.mean_mm !== want.mean_mm)
						bad = {bad, " light_distance_mm"};
					if (got.done !== want.done)
						bad = {bad, " scan_done"};
					if (got.short_scan !== want.short_scan)
						bad = {bad, " too_few_points"};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= MISMATCH_SHOWN)
							$display("report %0d wrong in%s: expected %s, got %s",
								reports_checked, bad, describe(want), describe(got));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: ends the run after too long with no handshake at all
	// ------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
			WATCHDOG_LIMIT, pending_reports.size());
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_MIN_RANGE;
		cfg_data = '0;
		item_valid = 1'b0;
		distance_mm = '0;
		reading_finite = 1'b0;
		angle_deg = '0;
		first_in_scan = 1'b0;
		last_in_scan = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		readings_sent = 0;
		reports_checked = 0;
		lights_checked = 0;
		short_scans = 0;
		reg_programs = 0;
		hold_offs = 0;
		mismatches = 0;
		build_cosine_table();
		reset_predictor();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender sparse, receiver mostly stalled
		send_idle_pct = 37;
		recv_stall_pct = 75;
		test_directed_cases();
		test_register_extremes();
		test_random_scans(130);

		// sender mostly idle, receiver sparse
		send_idle_pct = 75;
		recv_stall_pct = 37;
		test_random_scans(60);
		test_output_hold_off();

		// full rate on both sides
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_scans(60);
		test_output_hold_off();

		settle_block();
		if (pending_reports.size() != 0)
			mismatches++;
		$display("ran %0d readings in %0d register settings, %0d output hold-offs",
			readings_sent, reg_programs, hold_offs);
		$display("checked %0d reports: %0d lights, %0d short scans, %0d mismatches",
			reports_checked, lights_checked, short_scans, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/lscd_pkg.sv
design/lscd_sermul.sv
design/lscd_chord.sv
design/laser_scan_light_cluster_detector.sv
tb/sv/tb_laser_scan_light_cluster_detector.sv
